/* rtl/core/rrs_pkg.sv */
// ----------------------------------------------------------------------------
// rrs_pkg
// Shared types and fixed widths of the round robin event scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int TASK_IDX_W  = 3;
  localparam int EVENT_IDX_W = 3;
  localparam int SLEEP_W     = 32;
  localparam int TICK_W      = 16;
  localparam int CFG_W       = 4;

  localparam logic [CFG_W-1:0] TASK_COUNT_RESET = 4'd8;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_SWITCH = 2'd1,
    OP_TICK   = 2'd2,
    OP_SIGNAL = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_READY = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_SLEEP = 2'd2
  } mode_t;

  // block kind 3 behaves like "stays ready"
  localparam logic [1:0] KIND_READY = 2'd0;
  localparam logic [1:0] KIND_WAIT  = 2'd1;
  localparam logic [1:0] KIND_SLEEP = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIG_RD,
    ST_SIG_WR,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_SW_RD,
    ST_SW_STOP,
    ST_SW_APP,
    ST_SW_APP_WR,
    ST_SW_MOD,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_EV_CHK,
    ST_HEAD,
    ST_HEAD2,
    ST_FIN
  } state_t;

endpackage

/* rtl/core/round_robin_event_scheduler.sv */
// Steps: a switch stops the running task, may append it to a wait queue,
//   wraps its start around the ring, then visits tasks and wakes waiters;
//   task rows are read from a RAM with a registered read port.
// Throughput: one request at a time; the next request is taken once the
//   current one has finished, while the previous result may still wait.
// Reset: all tasks ready, no events, running task 0, task count 8.
// ----------------------------------------------------------------------------
// round_robin_event_scheduler
// Round robin task scheduler with event wait queues and sleep timers; task
// and event state live in two RAMs walked by a sequencer.
// ----------------------------------------------------------------------------
module round_robin_event_scheduler
  import rrs_pkg::*;
#(
  parameter int NUM_TASKS        = 8,
  parameter int NUM_EVENTS       = 8,
  parameter int EVENT_COUNT_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             opcode,
  input  logic [TASK_IDX_W-1:0]  task_index,
  input  logic [1:0]             block_kind,
  input  logic [EVENT_IDX_W-1:0] event_index,
  input  logic [SLEEP_W-1:0]     sleep_ms,
  input  logic [TICK_W-1:0]      tick_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [TASK_IDX_W-1:0]  running_task,
  output logic                   no_task_ready,
  output logic                   bad_index
);

  localparam int TW   = $clog2(NUM_TASKS);
  localparam int NW   = TW + 1;
  localparam int EW   = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int CB   = EVENT_COUNT_BITS;
  localparam int CMPW = (NW > CFG_W) ? NW : CFG_W;
  localparam logic [NW-1:0] EMPTY   = NW'(NUM_TASKS);
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

  typedef struct packed {
    logic [1:0]         mode;
    logic [EW-1:0]      evt;
    logic [SLEEP_W-1:0] sleep;
    logic [TW-1:0]      link;
  } trow_t;

  typedef struct packed {
    logic [CB-1:0] cnt;
    logic [NW-1:0] tail;
  } erow_t;

  localparam int TROW_W = $bits(trow_t);
  localparam int EROW_W = $bits(erow_t);

  function automatic logic [EW-1:0] ev_wrap(input logic [EVENT_IDX_W-1:0] v_in);
    logic [7:0] v;
    v = 8'(v_in);
    for (int k = 0; k < 8; k++) begin
      if (v >= 8'(NUM_EVENTS)) begin
        v = v - 8'(NUM_EVENTS);
      end
    end
    return v[EW-1:0];
  endfunction

  state_t state, state_next;

  logic [CFG_W-1:0]  task_count;
  logic [TW-1:0]     cur, cur_next;
  logic [NW-1:0]     pos, pos_next;
  logic [NW-1:0]     adv, adv_next;
  logic [1:0]        op_r;
  logic [1:0]        kind_r;
  logic [EW-1:0]     ev_r;
  logic [SLEEP_W-1:0] sms_r;
  logic [TICK_W-1:0] tms_r;
  logic [CB-1:0]     cnt_h, cnt_h_next;
  logic [TW-1:0]     tail_h, tail_h_next;
  logic [EW-1:0]     ev_h, ev_h_next;
  trow_t             hold_row, hold_row_next;
  logic [TW-1:0]     hold_link, hold_link_next;
  logic              res_none, res_none_next;
  logic              res_bad, res_bad_next;

  logic [NUM_TASKS-1:0]  tv;
  logic [NUM_EVENTS-1:0] evv;
  logic                  t_rv, e_rv;

  logic              t_we, e_we;
  logic [TW-1:0]     t_raddr, t_waddr;
  logic [EW-1:0]     e_raddr, e_waddr;
  trow_t             t_wdata, t_row;
  erow_t             e_wdata, e_row;
  logic [TROW_W-1:0] t_q;
  logic [EROW_W-1:0] e_q;

  logic              head_wr;
  trow_t             t_wdata_m;
  logic              t_we_m;
  logic [TW-1:0]     t_waddr_m;

  logic              in_acc, out_free;
  logic [CMPW-1:0]   tc_x, n_x, tidx_x;
  logic [NW-1:0]     ring_n;
  logic [NW-1:0]     pos_inc, pos_succ, adv_inc;
  logic              wake_ok, stop_ready, consume_now, app_link;
  logic [TW+TASK_IDX_W-1:0] cur_x;

  rrs_ram #(.WIDTH(TROW_W), .DEPTH(NUM_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (t_we_m),
    .waddr (t_waddr_m),
    .wdata (t_wdata_m),
    .raddr (t_raddr),
    .rdata (t_q)
  );

  rrs_ram #(.WIDTH(EROW_W), .DEPTH(NUM_EVENTS)) u_event_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_q)
  );

  // entries never written read as their reset values
  always_comb begin
    t_row = trow_t'(t_q);
    if (!t_rv) begin
      t_row = '{mode: MODE_READY, evt: '0, sleep: '0, link: '0};
    end
    e_row = erow_t'(e_q);
    if (!e_rv) begin
      e_row = '{cnt: '0, tail: EMPTY};
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign tc_x   = CMPW'(task_count);
  assign n_x    = (tc_x == '0) ? CMPW'(1) :
                  ((tc_x > CMPW'(NUM_TASKS)) ? CMPW'(NUM_TASKS) : tc_x);
  assign ring_n = n_x[NW-1:0];
  assign tidx_x = CMPW'(task_index);

  assign pos_inc  = pos + NW'(1);
  assign pos_succ = (pos_inc == ring_n) ? '0 : pos_inc;
  assign adv_inc  = adv + NW'(1);

  assign wake_ok     = (e_row.cnt != '0) && (e_row.tail < EMPTY);
  assign stop_ready  = (t_row.mode == MODE_READY);
  assign consume_now = (e_row.cnt != '0) && (e_row.tail >= EMPTY);
  assign app_link    = stop_ready && (kind_r == KIND_WAIT) && !consume_now &&
                       (e_row.tail < EMPTY);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (opcode_t'(opcode))
            OP_INIT:   state_next = ST_FIN;
            OP_SWITCH: state_next = ST_SW_RD;
            OP_TICK:   state_next = ST_TICK_RD;
            OP_SIGNAL: state_next = ST_SIG_RD;
          endcase
        end
      end
      ST_SIG_RD:    state_next = ST_SIG_WR;
      ST_SIG_WR:    state_next = ST_FIN;
      ST_TICK_RD:   state_next = ST_TICK_WR;
      ST_TICK_WR:   state_next = (pos_inc == ring_n) ? ST_FIN : ST_TICK_RD;
      ST_SW_RD:     state_next = ST_SW_STOP;
      ST_SW_STOP:   state_next = app_link ? ST_SW_APP : ST_SW_MOD;
      ST_SW_APP:    state_next = ST_SW_APP_WR;
      ST_SW_APP_WR: state_next = ST_SW_MOD;
      ST_SW_MOD:    state_next = (pos >= ring_n) ? ST_SW_MOD : ST_WALK_RD;
      ST_WALK_RD:   state_next = ST_WALK_CHK;
      ST_WALK_CHK: begin
        priority if (t_row.mode == MODE_READY) begin
          state_next = ST_FIN;
        end else if (t_row.mode == MODE_WAIT) begin
          state_next = ST_EV_CHK;
        end else begin
          state_next = (adv_inc >= ring_n) ? ST_FIN : ST_WALK_RD;
        end
      end
      ST_EV_CHK: begin
        priority if (wake_ok) begin
          state_next = ST_HEAD;
        end else begin
          state_next = (adv_inc >= ring_n) ? ST_FIN : ST_WALK_RD;
        end
      end
      ST_HEAD:   state_next = (t_row.link == tail_h) ? ST_WALK_RD : ST_HEAD2;
      // pass through SW_MOD so the head release lands before the next row read
      ST_HEAD2:  state_next = ST_SW_MOD;
      ST_FIN:    state_next = out_free ? ST_IDLE : ST_FIN;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cur_next       = cur;
    pos_next       = pos;
    adv_next       = adv;
    cnt_h_next     = cnt_h;
    tail_h_next    = tail_h;
    ev_h_next      = ev_h;
    hold_row_next  = hold_row;
    hold_link_next = hold_link;
    res_none_next  = res_none;
    res_bad_next   = res_bad;
    t_raddr = '0;
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = t_row;
    e_raddr = '0;
    e_we    = 1'b0;
    e_waddr = '0;
    e_wdata = e_row;
    unique case (state)
      ST_IDLE: begin
        res_none_next = 1'b0;
        res_bad_next  = 1'b0;
        pos_next      = '0;
        if (in_acc && (opcode_t'(opcode) == OP_INIT)) begin
          if (tidx_x < n_x) begin
            cur_next = tidx_x[TW-1:0];
          end else begin
            res_bad_next = 1'b1;
          end
        end
      end
      ST_SIG_RD: e_raddr = ev_r;
      ST_SIG_WR: begin
        e_we    = (e_row.cnt < CNT_MAX);
        e_waddr = ev_r;
        e_wdata.cnt = e_row.cnt + CB'(1);
      end
      ST_TICK_RD: t_raddr = pos[TW-1:0];
      ST_TICK_WR: begin
        t_waddr = pos[TW-1:0];
        t_we    = (t_row.mode == MODE_SLEEP);
        if (t_row.sleep > SLEEP_W'(tms_r)) begin
          t_wdata.sleep = t_row.sleep - SLEEP_W'(tms_r);
        end else begin
          t_wdata.sleep = '0;
          t_wdata.mode  = MODE_READY;
        end
        pos_next = pos_inc;
      end
      ST_SW_RD: begin
        t_raddr = cur;
        e_raddr = ev_r;
      end
      ST_SW_STOP: begin
        hold_row_next = t_row;
        cnt_h_next    = e_row.cnt;
        tail_h_next   = e_row.tail[TW-1:0];
        pos_next      = NW'(cur) + NW'(1);
        adv_next      = '0;
        t_raddr       = e_row.tail[TW-1:0];
        t_waddr       = cur;
        e_waddr       = ev_r;
        if (stop_ready) begin
          if (kind_r == KIND_WAIT) begin
            if (consume_now) begin
              e_we        = 1'b1;
              e_wdata.cnt = e_row.cnt - CB'(1);
            end else if (!app_link) begin
              // empty queue: the task links to itself
              t_we         = 1'b1;
              t_wdata.mode = MODE_WAIT;
              t_wdata.evt  = ev_r;
              t_wdata.link = cur;
              e_we         = 1'b1;
              e_wdata.tail = NW'(cur);
            end
          end else if (kind_r == KIND_SLEEP) begin
            t_we          = 1'b1;
            t_wdata.mode  = MODE_SLEEP;
            t_wdata.sleep = sms_r;
          end
        end
      end
      ST_SW_APP: begin
        // old tail now points at the new waiter
        hold_link_next = t_row.link;
        t_we           = 1'b1;
        t_waddr        = tail_h;
        t_wdata.link   = cur;
      end
      ST_SW_APP_WR: begin
        t_we         = 1'b1;
        t_waddr      = cur;
        t_wdata      = hold_row;
        t_wdata.mode = MODE_WAIT;
        t_wdata.evt  = ev_r;
        t_wdata.link = hold_link;
        e_we         = 1'b1;
        e_waddr      = ev_r;
        e_wdata.cnt  = cnt_h;
        e_wdata.tail = NW'(cur);
      end
      ST_SW_MOD: begin
        if (pos >= ring_n) begin
          pos_next = pos - ring_n;
        end
      end
      ST_WALK_RD: t_raddr = pos[TW-1:0];
      ST_WALK_CHK: begin
        e_raddr   = t_row.evt;
        ev_h_next = t_row.evt;
        priority if (t_row.mode == MODE_READY) begin
          cur_next = pos[TW-1:0];
        end else if (t_row.mode == MODE_WAIT) begin
          cur_next = cur;
        end else begin
          pos_next      = pos_succ;
          adv_next      = adv_inc;
          res_none_next = (adv_inc >= ring_n);
        end
      end
      ST_EV_CHK: begin
        cnt_h_next  = e_row.cnt - CB'(1);
        tail_h_next = e_row.tail[TW-1:0];
        t_raddr     = e_row.tail[TW-1:0];
        priority if (wake_ok) begin
          adv_next = '0;
        end else begin
          pos_next      = pos_succ;
          adv_next      = adv_inc;
          res_none_next = (adv_inc >= ring_n);
        end
      end
      ST_HEAD: begin
        // t_row is the tail; its link is the queue head
        hold_row_next  = t_row;
        hold_link_next = t_row.link;
        t_raddr        = t_row.link;
        e_waddr        = ev_h;
        e_wdata.cnt    = cnt_h;
        if (t_row.link == tail_h) begin
          t_we         = 1'b1;
          t_waddr      = tail_h;
          t_wdata.mode = MODE_READY;
          t_wdata.evt  = '0;
          t_wdata.link = '0;
          e_we         = 1'b1;
          e_wdata.tail = EMPTY;
        end
      end
      ST_HEAD2: begin
        // unlink the head from the tail, then release the head
        t_we         = 1'b1;
        t_waddr      = tail_h;
        t_wdata      = hold_row;
        t_wdata.link = t_row.link;
        hold_row_next = t_row;
        e_we         = 1'b1;
        e_waddr      = ev_h;
        e_wdata.cnt  = cnt_h;
        e_wdata.tail = NW'(tail_h);
      end
      ST_FIN: begin
        cur_next = cur;
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  // the head row write of a multi entry queue needs its own cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      head_wr <= 1'b0;
    end else begin
      head_wr <= (state == ST_HEAD2);
    end
  end

  always_comb begin
    t_we_m    = t_we;
    t_waddr_m = t_waddr;
    t_wdata_m = t_wdata;
    if (head_wr) begin
      t_we_m         = 1'b1;
      t_waddr_m      = hold_link;
      t_wdata_m      = hold_row;
      t_wdata_m.mode = MODE_READY;
      t_wdata_m.evt  = '0;
      t_wdata_m.link = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      task_count <= TASK_COUNT_RESET;
      cur        <= '0;
      tv         <= '0;
      evv        <= '0;
      t_rv       <= 1'b0;
      e_rv       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      if (cfg_we) begin
        task_count <= cfg_wdata;
      end
      if (t_we_m) begin
        tv[t_waddr_m] <= 1'b1;
      end
      if (e_we) begin
        evv[e_waddr] <= 1'b1;
      end
      t_rv <= tv[t_raddr];
      e_rv <= evv[e_raddr];
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cur_x = (TW + TASK_IDX_W)'(cur);

  always_ff @(posedge clk) begin
    pos       <= pos_next;
    adv       <= adv_next;
    cnt_h     <= cnt_h_next;
    tail_h    <= tail_h_next;
    ev_h      <= ev_h_next;
    hold_row  <= hold_row_next;
    hold_link <= hold_link_next;
    res_none  <= res_none_next;
    res_bad   <= res_bad_next;
    if (in_acc) begin
      op_r   <= opcode;
      kind_r <= block_kind;
      ev_r   <= ev_wrap(event_index);
      sms_r  <= sleep_ms;
      tms_r  <= tick_ms;
    end
    if ((state == ST_FIN) && out_free) begin
      running_task  <= cur_x[TASK_IDX_W-1:0];
      no_task_ready <= res_none && (op_r == OP_SWITCH);
      bad_index     <= res_bad;
    end
  end

  a_walk_in_ring: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK_CHK) |-> (pos < ring_n && adv < ring_n))
    else $error("walk position or step count left the ring");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result raised outside the finish state");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(no_task_ready && bad_index))
    else $error("both result flags set");

  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    (NW'(cur) < EMPTY))
    else $error("running task beyond task storage");

endmodule

/* rtl/core/rrs_ram.sv */
// ----------------------------------------------------------------------------
// rrs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for round_robin_event_scheduler: a behavioral scheduler
// model predicts every result, requests and results flow with random gaps.
// ----------------------------------------------------------------------------
module tb_top
  import rrs_pkg::*;
();

  localparam int NT = 8;
  localparam int NE = 8;
  localparam logic [7:0] CNT_MAX = 8'hFF;
  localparam int WDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [2:0] task_q;
    logic       none_q;
    logic       bad_q;
  } sched_res_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [2:0] task_index = '0;
  logic [1:0] block_kind = '0;
  logic [2:0] event_index = '0;
  logic [31:0] sleep_ms = '0;
  logic [15:0] tick_ms = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] running_task;
  logic no_task_ready;
  logic bad_index;

  round_robin_event_scheduler u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .task_index(task_index), .block_kind(block_kind), .event_index(event_index),
    .sleep_ms(sleep_ms), .tick_ms(tick_ms), .out_valid(out_valid),
    .out_stall(out_stall), .running_task(running_task),
    .no_task_ready(no_task_ready), .bad_index(bad_index)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // scheduler shadow state
  logic [3:0]  m_count;
  logic [2:0]  m_cur;
  mode_t       m_mode [NT];
  logic [2:0]  m_evt [NT];
  logic [31:0] m_sleep [NT];
  logic [7:0]  m_ecnt [NE];
  logic [3:0]  m_tail [NE];
  logic [2:0]  m_link [NT];

  sched_res_t sched_expected[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  event hold_go;

  function automatic int ring_n();
    if (m_count < 1) return 1;
    if (m_count > NT) return NT;
    return m_count;
  endfunction

  task automatic model_reset();
    m_count = TASK_COUNT_RESET;
    m_cur = '0;
    for (int i = 0; i < NT; i++) begin
      m_mode[i] = MODE_READY; m_evt[i] = '0; m_sleep[i] = '0; m_link[i] = '0;
    end
    for (int i = 0; i < NE; i++) begin
      m_ecnt[i] = '0; m_tail[i] = 4'(NT);
    end
  endtask

  function automatic void enqueue_waiter(int ev, int t);
    if (m_tail[ev] >= NT) m_link[t] = 3'(t);
    else begin
      m_link[t] = m_link[m_tail[ev]];
      m_link[m_tail[ev]] = 3'(t);
    end
    m_tail[ev] = 4'(t);
  endfunction

  function automatic void pop_waiter(int ev);
    int tl, hd;
    tl = m_tail[ev];
    hd = m_link[tl];
    if (hd == tl) m_tail[ev] = 4'(NT);
    else m_link[tl] = m_link[hd];
    m_link[hd] = '0;
    m_mode[hd] = MODE_READY;
    m_evt[hd] = '0;
  endfunction

  function automatic bit switch_task(logic [1:0] kind, int ev, logic [31:0] ms);
    int n, stopped, p, adv, e;
    n = ring_n();
    stopped = m_cur;
    if (m_mode[stopped] == MODE_READY) begin
      if (kind == KIND_WAIT) begin
        if (m_ecnt[ev] > 0 && m_tail[ev] >= NT) m_ecnt[ev]--;
        else begin
          m_mode[stopped] = MODE_WAIT;
          m_evt[stopped] = 3'(ev);
          enqueue_waiter(ev, stopped);
        end
      end else if (kind == KIND_SLEEP) begin
        m_mode[stopped] = MODE_SLEEP;
        m_sleep[stopped] = ms;
      end
    end
    p = (stopped + 1) % n;
    adv = 0;
    forever begin
      e = m_evt[p];
      if (m_mode[p] == MODE_READY) begin
        m_cur = 3'(p);
        return 1'b1;
      end
      if (m_mode[p] == MODE_WAIT && m_ecnt[e] > 0 && m_tail[e] < NT) begin
        m_ecnt[e]--;
        pop_waiter(e);
        adv = 0;
      end else begin
        p = (p + 1) % n;
        adv++;
        if (adv >= n) return 1'b0;
      end
    end
  endfunction

  function automatic sched_res_t predict_sched(logic [1:0] op, logic [2:0] tidx,
      logic [1:0] kind, logic [2:0] ev, logic [31:0] sms, logic [15:0] tms);
    sched_res_t r;
    int n;
    n = ring_n();
    r = '0;
    case (op)
      OP_INIT: begin
        if (tidx < n) m_cur = tidx;
        else r.bad_q = 1'b1;
      end
      OP_SWITCH: r.none_q = !switch_task(kind, ev, sms);
      OP_TICK: begin
        for (int i = 0; i < n; i++) begin
          if (m_mode[i] == MODE_SLEEP) begin
            if (m_sleep[i] > tms) m_sleep[i] -= tms;
            else begin
              m_sleep[i] = '0; m_mode[i] = MODE_READY;
            end
          end
        end
      end
      default: if (m_ecnt[ev] < CNT_MAX) m_ecnt[ev]++;
    endcase
    r.task_q = m_cur;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // valid stays up between back to back requests; a gap or drain lowers it
  task automatic send_request(logic [1:0] op, logic [2:0] tidx, logic [1:0] kind,
      logic [2:0] ev, logic [31:0] sms, logic [15:0] tms);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1; opcode <= op; task_index <= tidx; block_kind <= kind;
    event_index <= ev; sleep_ms <= sms; tick_ms <= tms;
    do @(posedge clk); while (in_stall);
    sched_expected.push_back(predict_sched(op, tidx, kind, ev, sms, tms));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sched_expected.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_count(logic [3:0] v);
    drain();
    cfg_we <= 1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    m_count = v;
  endtask

  // receiver stall
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else if ($urandom_range(0, 3) == 0) out_stall <= ($urandom_range(0, 9) < 7);
    else out_stall <= 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sched_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result task=%0d", running_task);
      end else begin
        sched_res_t x;
        x = sched_expected.pop_front();
        if (x.task_q !== running_task || x.none_q !== no_task_ready ||
            x.bad_q !== bad_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp task=%0d none=%0d bad=%0d got task=%0d none=%0d bad=%0d",
              x.task_q, x.none_q, x.bad_q, running_task, no_task_ready, bad_index);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_go);
      hold_off = 1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 0;
    end
  end

  task automatic rand_request(bit biased);
    logic [1:0] op;
    logic [31:0] sms;
    logic [2:0] ev;
    logic [15:0] tms;
    op = 2'($urandom_range(0, 3));
    sms = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300);
    ev = biased ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
    tms = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 65535)) :
      16'($urandom_range(0, 200));
    send_request(op, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), ev, sms, tms);
  endtask

  task automatic test_directed();
    send_request(OP_INIT, 3'd7, KIND_READY, 3'd0, 32'd0, 16'd0);
    send_request(OP_SWITCH, 3'd0, KIND_READY, 3'd0, 32'd0, 16'd0);
    send_request(OP_SWITCH, 3'd0, KIND_WAIT, 3'd7, 32'd0, 16'd0);
    send_request(OP_SWITCH, 3'd0, KIND_SLEEP, 3'd0, 32'hFFFFFFFF, 16'd0);
    send_request(OP_SWITCH, 3'd0, KIND_SLEEP, 3'd0, 32'd0, 16'd0);
    send_request(OP_SWITCH, 3'd0, 2'd3, 3'd0, 32'd0, 16'd0);
    send_request(OP_TICK, 3'd0, KIND_READY, 3'd0, 32'd0, 16'd0);
    send_request(OP_TICK, 3'd0, KIND_READY, 3'd0, 32'd0, 16'hFFFF);
    send_request(OP_SIGNAL, 3'd0, KIND_READY, 3'd7, 32'd0, 16'd0);
    send_request(OP_SWITCH, 3'd0, KIND_WAIT, 3'd7, 32'd0, 16'd0);
    send_request(OP_SIGNAL, 3'd0, KIND_READY, 3'd3, 32'd0, 16'd0);
    for (int i = 0; i < 4; i++)
      send_request(OP_SWITCH, 3'd0, KIND_WAIT, 3'd2, 32'd0, 16'd0);
    send_request(OP_SIGNAL, 3'd0, KIND_READY, 3'd2, 32'd0, 16'd0);
    send_request(OP_SWITCH, 3'd0, KIND_READY, 3'd0, 32'd0, 16'd0);
    for (int i = 0; i < 4; i++)
      send_request(OP_SWITCH, 3'd0, KIND_WAIT, 3'd5, 32'd0, 16'd0);
    send_request(OP_SWITCH, 3'd0, KIND_WAIT, 3'd5, 32'd0, 16'd0);
    send_request(OP_SIGNAL, 3'd0, KIND_READY, 3'd5, 32'd0, 16'd0);
    send_request(OP_SWITCH, 3'd0, KIND_READY, 3'd0, 32'd0, 16'd0);
  endtask

  task automatic test_count_settings();
    logic [3:0] vals [6];
    vals = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd8};
    foreach (vals[k]) begin
      write_count(vals[k]);
      send_request(OP_INIT, 3'd7, KIND_READY, 3'd0, 32'd0, 16'd0);
      send_request(OP_INIT, vals[k] == 0 ? 3'd0 : 3'd1, KIND_READY, 3'd0, 32'd0, 16'd0);
      for (int i = 0; i < 120; i++) rand_request(1'b1);
    end
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 260; i++)
      send_request(OP_SIGNAL, 3'd0, KIND_READY, 3'd6, 32'd0, 16'd0);
  endtask

  task automatic test_backpressure();
    -> hold_go;
    for (int i = 0; i < 20; i++)
      send_request(OP_SIGNAL, 3'd0, KIND_READY, 3'd1, 32'd0, 16'd0);
  endtask

  task automatic test_random();
    for (int i = 0; i < 360; i++) rand_request($urandom_range(0, 3) != 0);
  endtask

  initial begin
    model_reset();
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_count_settings();
    test_saturation();
    test_random();
    drain();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
